// File: src/assert_macros.svh
// Assertion macros shared by the segment LCD frame composer RTL.
// Needs nothing but the clock and reset names handed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// Check that a trigger is followed by a condition in the next cycle
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed: label");

`endif

// File: src/slcd_pkg.sv
// Shared types, glyph tables and decimal digit helper for the segment LCD
// frame composer. Depends on nothing; every other .sv source file uses it.
`timescale 1ns / 1ps

package slcd_pkg;

   // Register index of the configuration port
   localparam logic REG_DISPLAY_ENABLED = 1'b0;

   // Decimal place selectors for dec_digit
   localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
   localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
   localparam logic [1:0] PLACE_TENS      = 2'd2;

   // Multiples of each decimal place, k times the place for k = 0..9
   localparam logic [13:0] PLACE_MULT [3][10] = '{
      '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
      '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
        14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
      '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
        14'd50, 14'd60, 14'd70, 14'd80, 14'd90}
   };

   // Glyphs for the large field's upper digits
   localparam logic [7:0] GLYPH_HI7 [10] = '{
      8'hFA, 8'h60, 8'hD6, 8'hF4, 8'h6C, 8'hBC, 8'hBE, 8'hE0, 8'hFE, 8'hFC
   };
   // Glyphs for the large field's last digit, split over bytes 4 and 5
   localparam logic [7:0] GLYPH_MID [10] = '{
      8'hAF, 8'h06, 8'h6D, 8'h4F, 8'hC6, 8'hCB, 8'hEB, 8'h0E, 8'hEF, 8'hCF
   };
   // Glyphs for the small field
   localparam logic [7:0] GLYPH_SM [10] = '{
      8'h5F, 8'h06, 8'h6B, 8'h2F, 8'h36, 8'h3D, 8'h7D, 8'h07, 8'h7F, 8'h3F
   };

   typedef struct packed {
      logic [3:0]  q;
      logic [13:0] r;
   } digit_split_type;

   // Segments produced by the large field
   typedef struct packed {
      logic [7:0] seg7;
      logic [7:0] seg6;
      logic [2:0] mid_hi;   // byte 5 bits 7..5
      logic [3:0] mid_lo;   // byte 4 bits 3..0
      logic       point;    // byte 5 bit 0
   } big_seg_type;

   // Split off one decimal digit: nine parallel compares against the
   // multiples of the chosen place, value below ten times that place.
   function automatic digit_split_type dec_digit(input logic [13:0] v,
                                                 input logic [1:0]  place);
      digit_split_type res;
      res.q = 4'd0;
      res.r = v;
      for (int k = 1; k < 10; k++) begin
         if (v >= PLACE_MULT[place][k]) begin
            res.q = 4'(k);
            res.r = v - PLACE_MULT[place][k];
         end
      end
      return res;
   endfunction

endpackage

// File: src/slcd_csr.sv
// Configuration register block of the segment LCD frame composer.
// Uses slcd_pkg for the register index.
`timescale 1ns / 1ps

module slcd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic        display_enabled
);

   logic display_enabled_ff;
   logic display_enabled_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr[2] == slcd_pkg::REG_DISPLAY_ENABLED);

   // Take a write in the access phase
   always_comb begin
      display_enabled_in = display_enabled_ff;
      if (wr_en) begin
         display_enabled_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_enabled_ff <= 1'b1;
      end else begin
         display_enabled_ff <= display_enabled_in;
      end
   end

   // Read back; the unused address reads as zero
   assign csr_prdata = (csr_paddr[2] == slcd_pkg::REG_DISPLAY_ENABLED)
                       ? {31'd0, display_enabled_ff} : 32'd0;

   assign display_enabled = display_enabled_ff;

endmodule

// File: src/slcd_big_field.sv
// Large three-and-a-half digit field: Hi/Lo, rounding of large values and
// decimal point handling. Uses slcd_pkg for glyphs and digit splitting.
`timescale 1ns / 1ps

module slcd_big_field (
   input  logic signed [15:0]  big_value,
   output slcd_pkg::big_seg_type seg
);

   localparam logic signed [15:0] HI_LIMIT    = 16'sd19995;
   localparam logic signed [15:0] LO_LIMIT    = -16'sd995;
   localparam logic signed [15:0] POINT_LIMIT = 16'sd1995;
   localparam logic [15:0] ROUND_HALF   = 16'd5;
   localparam logic [14:0] TEN_K        = 15'd10000;
   localparam logic [14:0] TWENTY_K     = 15'd20000;
   localparam logic [14:0] ONE_K        = 15'd1000;
   localparam logic [14:0] ONE_HUNDRED  = 15'd100;
   localparam logic [7:0]  HI_SEG7      = 8'h6E;
   localparam logic [7:0]  HI_SEG6      = 8'h02;
   localparam logic [7:0]  LO_SEG7      = 8'h1A;
   localparam logic [7:0]  LO_SEG6      = 8'h36;
   localparam logic [7:0]  MINUS_SEG6   = 8'h04;
   localparam logic [7:0]  LEAD_ONE     = 8'h01;

   logic        is_hi, is_lo, is_large, is_neg;
   logic [15:0] sum_val, neg_val;
   logic [14:0] mag;
   logic [13:0] low_part;
   logic        lead, show_hund;
   logic [3:0]  hund_d, tens_d, ones_d;
   logic [7:0]  mid_glyph;
   slcd_pkg::digit_split_type s3, s2, s1;

   assign is_hi    = big_value > HI_LIMIT;
   assign is_lo    = big_value < LO_LIMIT;
   assign is_large = big_value > POINT_LIMIT;
   assign is_neg   = big_value[15];

   // Magnitude to show; large values carry the rounding half
   assign sum_val = $unsigned(big_value) + ROUND_HALF;
   assign neg_val = 16'd0 - $unsigned(big_value);
   assign mag = is_large ? sum_val[14:0] : (is_neg ? neg_val[14:0] : big_value[14:0]);

   // Drop the ten-thousands, then split the remaining digits
   assign low_part = (mag >= TWENTY_K) ? 14'(mag - TWENTY_K)
                   : (mag >= TEN_K)    ? 14'(mag - TEN_K) : mag[13:0];
   assign s3 = slcd_pkg::dec_digit(low_part, slcd_pkg::PLACE_THOUSANDS);
   assign s2 = slcd_pkg::dec_digit(s3.r, slcd_pkg::PLACE_HUNDREDS);
   assign s1 = slcd_pkg::dec_digit(s2.r, slcd_pkg::PLACE_TENS);

   // Large values drop their last digit, which stands for the division by ten
   always_comb begin
      if (is_large) begin
         lead      = mag >= TEN_K;
         show_hund = mag >= ONE_K;
         hund_d    = s3.q;
         tens_d    = s2.q;
         ones_d    = s1.q;
      end else begin
         lead      = mag >= ONE_K;
         show_hund = mag >= ONE_HUNDRED;
         hund_d    = s2.q;
         tens_d    = s1.q;
         ones_d    = s1.r[3:0];
      end
   end

   assign mid_glyph = slcd_pkg::GLYPH_MID[ones_d];

   // Assemble the field, Hi and Lo override the digits
   always_comb begin
      if (is_hi) begin
         seg.seg7   = HI_SEG7;
         seg.seg6   = HI_SEG6;
         seg.mid_hi = 3'd0;
         seg.mid_lo = 4'd0;
         seg.point  = 1'b0;
      end else if (is_lo) begin
         seg.seg7   = LO_SEG7;
         seg.seg6   = LO_SEG6;
         seg.mid_hi = 3'd0;
         seg.mid_lo = 4'd0;
         seg.point  = 1'b0;
      end else begin
         seg.seg7   = (lead ? LEAD_ONE : 8'd0)
                      | (show_hund ? slcd_pkg::GLYPH_HI7[hund_d] : 8'd0);
         seg.seg6   = (is_neg ? MINUS_SEG6 : 8'd0) | slcd_pkg::GLYPH_HI7[tens_d];
         seg.mid_hi = mid_glyph[7:5];
         seg.mid_lo = mid_glyph[3:0];
         seg.point  = !is_large;
      end
   end

endmodule

// File: src/slcd_small_field.sv
// Small two digit field with Hi/Lo and minus sign.
// Uses slcd_pkg for glyphs and digit splitting.
`timescale 1ns / 1ps

module slcd_small_field (
   input  logic signed [15:0] small_value,
   output logic [7:0]         seg1,
   output logic [7:0]         seg2
);

   localparam logic signed [15:0] HI_LIMIT = 16'sd99;
   localparam logic signed [15:0] LO_LIMIT = -16'sd9;
   localparam logic [7:0] HI_SEG1    = 8'h76;
   localparam logic [7:0] HI_SEG2    = 8'h40;
   localparam logic [7:0] LO_SEG1    = 8'h58;
   localparam logic [7:0] LO_SEG2    = 8'h6C;
   localparam logic [7:0] MINUS_SEG1 = 8'h20;

   logic        is_hi, is_lo, is_neg;
   logic [15:0] neg_val;
   logic [6:0]  mag;
   slcd_pkg::digit_split_type ts;

   assign is_hi   = small_value > HI_LIMIT;
   assign is_lo   = small_value < LO_LIMIT;
   assign is_neg  = small_value[15];
   assign neg_val = 16'd0 - $unsigned(small_value);
   assign mag     = is_neg ? neg_val[6:0] : small_value[6:0];
   assign ts      = slcd_pkg::dec_digit({7'd0, mag}, slcd_pkg::PLACE_TENS);

   // Tens digit or minus sign in byte 1, units in byte 2
   always_comb begin
      if (is_hi) begin
         seg1 = HI_SEG1;
         seg2 = HI_SEG2;
      end else if (is_lo) begin
         seg1 = LO_SEG1;
         seg2 = LO_SEG2;
      end else begin
         if (ts.q != 4'd0) begin
            seg1 = slcd_pkg::GLYPH_SM[ts.q];
         end else if (is_neg) begin
            seg1 = MINUS_SEG1;
         end else begin
            seg1 = 8'd0;
         end
         seg2 = slcd_pkg::GLYPH_SM[ts.r[3:0]];
      end
   end

endmodule

// File: src/segment_lcd_frame_composer.sv
// Segment LCD frame composer: one display update word in, one 8-byte frame out.
// A word taken waits in the input register and moves into the result register once that register is free.
// Throughput: one word per cycle; the input register and result register
// stall together only while rsp_tready is low and the result is still held.
// Reset (synchronous, active high) clears both valids and the work and sent
// frames, and sets display_enabled to one.
`timescale 1ns / 1ps

module segment_lcd_frame_composer (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, from bit 0: big_value[15:0], small_value[31:16],
   // percent_sign[32], battery_on[33], battery_level[41:34],
   // smiley_code[44:42], unit_code[47:45]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata, from bit 0: frame[63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // rsp_tuser, from bit 0: changed[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "assert_macros.svh"

   localparam logic [7:0] BAR1_LEVEL = 8'd20;
   localparam logic [7:0] BAR2_LEVEL = 8'd36;
   localparam logic [7:0] BAR3_LEVEL = 8'd52;
   localparam logic [7:0] BAR4_LEVEL = 8'd68;
   localparam logic [7:0] BAR5_LEVEL = 8'd84;

   logic        display_enabled;
   logic        s1_valid_ff, s1_valid_in;
   logic [47:0] s1_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_frame_ff;
   logic        rsp_changed_ff;
   logic [63:0] work_frame_ff, work_frame_in;
   logic [63:0] sent_frame_ff, sent_frame_in;
   logic        s1_advance;
   logic        req_take;
   logic        frame_changed;

   logic signed [15:0] big_value, small_value;
   logic        percent_sign, battery_on;
   logic [7:0]  battery_level;
   logic [2:0]  smiley_code, unit_code;
   slcd_pkg::big_seg_type big_seg;
   logic [7:0]  seg0, seg1, seg2, seg3, seg4, seg5;
   logic [63:0] frame;

   slcd_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .display_enabled (display_enabled)
   );

   // Handshake: the input register moves on whenever the result register frees
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   // Unpack the held word
   assign big_value     = $signed(s1_data_ff[15:0]);
   assign small_value   = $signed(s1_data_ff[31:16]);
   assign percent_sign  = s1_data_ff[32];
   assign battery_on    = s1_data_ff[33];
   assign battery_level = s1_data_ff[41:34];
   assign smiley_code   = s1_data_ff[44:42];
   assign unit_code     = s1_data_ff[47:45];

   slcd_big_field u_big (
      .big_value (big_value),
      .seg       (big_seg)
   );

   slcd_small_field u_small (
      .small_value (small_value),
      .seg1        (seg1),
      .seg2        (seg2)
   );

   // Smiley segments; the upper nibble keeps what the last frame held
   assign seg0 = {work_frame_ff[7:4], smiley_code[0], smiley_code[1],
                  smiley_code[0] | smiley_code[1], smiley_code[2]};

   // Battery bars; untouched segments of byte 3 hold
   assign seg3 = {work_frame_ff[31],
                  battery_on && (battery_level > BAR1_LEVEL),
                  battery_on && (battery_level > BAR2_LEVEL),
                  work_frame_ff[28], work_frame_ff[27],
                  battery_on && (battery_level > BAR4_LEVEL),
                  battery_on && (battery_level > BAR3_LEVEL),
                  work_frame_ff[24]};

   // Percent, battery outline and top bar, low half of the last big digit
   assign seg4 = {percent_sign, battery_on,
                  battery_on && (battery_level > BAR5_LEVEL),
                  1'b0, big_seg.mid_lo};

   // Upper half of the last big digit, unit segments and the point
   assign seg5 = {big_seg.mid_hi, 1'b0, unit_code[0], unit_code[2], unit_code[1],
                  big_seg.point};

   assign frame = {big_seg.seg7, big_seg.seg6, seg5, seg4, seg3, seg2, seg1, seg0};
   assign frame_changed = display_enabled && (frame != sent_frame_ff);

   // Next state of valids and frame copies
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      work_frame_in = work_frame_ff;
      sent_frame_in = sent_frame_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         s1_valid_in   = 1'b0;
         rsp_valid_in  = 1'b1;
         work_frame_in = frame;
         if (frame_changed) begin
            sent_frame_in = frame;
         end
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         work_frame_ff <= 64'd0;
         sent_frame_ff <= 64'd0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         work_frame_ff <= work_frame_in;
         sent_frame_ff <= sent_frame_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_tdata;
      end
      if (s1_advance) begin
         rsp_frame_ff   <= frame;
         rsp_changed_ff <= frame_changed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_frame_ff;
   assign rsp_tuser  = rsp_changed_ff;

   // A frame flagged as changed is the one now marked as sent
   `ASSERT_ALWAYS(a_changed_is_sent, clock, reset,
                  !(rsp_valid_ff && rsp_changed_ff) || (sent_frame_ff == rsp_frame_ff))
   // Both registers full and the output stalled: no word may be taken
   `ASSERT_ALWAYS(a_full_blocks_input, clock, reset,
                  !(s1_valid_ff && rsp_valid_ff && !rsp_tready) || !req_tready)
   // A disabled display never flags a change
   `ASSERT_NEXT(a_disabled_no_change, clock, reset,
                s1_advance && !display_enabled, !rsp_changed_ff)

endmodule

// File: dv/tb_segment_lcd_frame_composer.sv
// Self-checking testbench for the segment LCD frame composer: streams display
// updates in, predicts each 8-byte frame and change flag, and checks every result word.
// Depends on slcd_pkg and the segment_lcd_frame_composer RTL.
`timescale 1ns / 1ps

module tb_segment_lcd_frame_composer;

   // One display update, laid out as on req_tdata (last field lowest)
   typedef struct packed {
      logic [2:0]         unit_code;
      logic [2:0]         smiley_code;
      logic [7:0]         battery_level;
      logic               battery_on;
      logic               percent_sign;
      logic signed [15:0] small_value;
      logic signed [15:0] big_value;
   } lcd_update_type;

   typedef struct packed {
      logic [63:0] frame;
      logic        changed;
   } panel_result_type;

   localparam logic [2:0] DISPLAY_ENABLE_ADDR = {slcd_pkg::REG_DISPLAY_ENABLED, 2'b00};
   localparam int         STALL_LIMIT         = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lcd_update_type   pending_updates[$];
   panel_result_type expected_frames[$];
   lcd_update_type   last_update = '0;

   // Predictor state
   logic [63:0] panel_work    = '0;
   logic [63:0] panel_sent    = '0;
   logic        panel_enabled = 1'b1;

   int  error_count  = 0;
   int  quiet_cycles = 0;
   bit  no_idling    = 1'b0;
   int  src_gap      = 0;
   int  sink_gap     = 0;
   int  src_idle_pct = 10;
   int  sink_idle_pct = 10;
   int  rate_cycle   = 0;

   segment_lcd_frame_composer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Glyphs of the large field's upper digits
   function automatic logic [7:0] upper_glyph(input int d);
      case (d)
         0: return 8'hFA;  1: return 8'h60;  2: return 8'hD6;  3: return 8'hF4;
         4: return 8'h6C;  5: return 8'hBC;  6: return 8'hBE;  7: return 8'hE0;
         8: return 8'hFE;  default: return 8'hFC;
      endcase
   endfunction

   // Glyphs of the large field's last digit, split over bytes 4 and 5
   function automatic logic [7:0] last_glyph(input int d);
      case (d)
         0: return 8'hAF;  1: return 8'h06;  2: return 8'h6D;  3: return 8'h4F;
         4: return 8'hC6;  5: return 8'hCB;  6: return 8'hEB;  7: return 8'h0E;
         8: return 8'hEF;  default: return 8'hCF;
      endcase
   endfunction

   // Glyphs of the small field
   function automatic logic [7:0] pair_glyph(input int d);
      case (d)
         0: return 8'h5F;  1: return 8'h06;  2: return 8'h6B;  3: return 8'h2F;
         4: return 8'h36;  5: return 8'h3D;  6: return 8'h7D;  7: return 8'h07;
         8: return 8'h7F;  default: return 8'h3F;
      endcase
   endfunction

   // Build the next frame from the working copy; advance the sent copy when enabled and changed
   function automatic panel_result_type compose_panel(input lcd_update_type u);
      logic [7:0]       seg [8];
      int               n;
      int               m;
      panel_result_type r;
      for (int i = 0; i < 8; i++) seg[i] = panel_work[8*i +: 8];

      // large field
      n = int'($signed(u.big_value));
      seg[5] &= 8'h0E;
      seg[4] &= 8'hE0;
      if (n > 19995) begin
         seg[7] = 8'h6E;
         seg[6] = 8'h02;
      end else if (n < -995) begin
         seg[7] = 8'h1A;
         seg[6] = 8'h36;
      end else begin
         seg[6] = 8'h00;
         seg[7] = 8'h00;
         if (n > 1995) begin
            m = (n + 5) / 10;
         end else begin
            seg[5] |= 8'h01;
            if (n < 0) begin
               seg[6] = 8'h04;
               m = -n;
            end else begin
               m = n;
            end
         end
         if (m > 999) seg[7] = 8'h01;
         if (m > 99) seg[7] |= upper_glyph((m / 100) % 10);
         if (m > 9) seg[6] |= upper_glyph((m / 10) % 10);
         else seg[6] |= upper_glyph(0);
         seg[4] |= last_glyph(m % 10) & 8'h0F;
         seg[5] |= last_glyph(m % 10) & 8'hE0;
      end

      // small field and percent sign
      n = int'($signed(u.small_value));
      if (u.percent_sign) seg[4] |= 8'h80;
      else seg[4] &= 8'h7F;
      if (n > 99) begin
         seg[1] = 8'h76;
         seg[2] = 8'h40;
      end else if (n < -9) begin
         seg[1] = 8'h58;
         seg[2] = 8'h6C;
      end else begin
         seg[1] = 8'h00;
         if (n < 0) begin
            seg[1] = 8'h20;
            m = -n;
         end else begin
            m = n;
         end
         if (m > 9) seg[1] = pair_glyph((m / 10) % 10);
         seg[2] = pair_glyph(m % 10);
      end

      // battery outline and bars
      seg[3] &= 8'h99;
      seg[4] &= 8'h9F;
      if (u.battery_on) begin
         seg[4] |= 8'h40;
         if (u.battery_level > 84) seg[4] |= 8'h20;
         if (u.battery_level > 68) seg[3] |= 8'h04;
         if (u.battery_level > 52) seg[3] |= 8'h02;
         if (u.battery_level > 36) seg[3] |= 8'h20;
         if (u.battery_level > 20) seg[3] |= 8'h40;
      end

      // smiley and temperature unit
      seg[0] &= 8'hF0;
      if (u.smiley_code[0]) seg[0] |= 8'h0A;
      if (u.smiley_code[1]) seg[0] |= 8'h06;
      if (u.smiley_code[2]) seg[0] |= 8'h01;
      seg[5] &= 8'hF1;
      if (u.unit_code[0]) seg[5] |= 8'h08;
      if (u.unit_code[1]) seg[5] |= 8'h02;
      if (u.unit_code[2]) seg[5] |= 8'h04;

      for (int i = 0; i < 8; i++) r.frame[8*i +: 8] = seg[i];
      panel_work = r.frame;
      r.changed  = 1'b0;
      if (panel_enabled && r.frame != panel_sent) begin
         panel_sent = r.frame;
         r.changed  = 1'b1;
      end
      return r;
   endfunction

   task automatic add_update(input int big_v, input int small_v, input bit pct,
                             input bit bat_on, input int level, input int smile,
                             input int unit_v);
      lcd_update_type u;
      u.big_value     = 16'(big_v);
      u.small_value   = 16'(small_v);
      u.percent_sign  = pct;
      u.battery_on    = bat_on;
      u.battery_level = 8'(level);
      u.smiley_code   = 3'(smile);
      u.unit_code     = 3'(unit_v);
      pending_updates.push_back(u);
      last_update = u;
   endtask

   function automatic int pick_big_boundary();
      case ($urandom_range(0, 15))
         0: return 19995;   1: return 19996;   2: return -995;   3: return -996;
         4: return 1995;    5: return 1996;    6: return 999;    7: return 1000;
         8: return -999;    9: return 99;      10: return 100;   11: return 9;
         12: return -9;     13: return 10;     14: return 0;     default: return -1;
      endcase
   endfunction

   // Random update, mixing values inside and outside the displayable ranges
   task automatic add_random_update();
      int big_v;
      int small_v;
      int level;
      if ($urandom_range(0, 7) == 0) begin
         // repeat the last word so that the change flag stays low
         pending_updates.push_back(last_update);
         return;
      end
      case ($urandom_range(0, 6))
         0: big_v = int'($urandom_range(0, 65535));
         1, 2: big_v = int'($urandom_range(0, 2990)) - 995;
         3: big_v = 1996 + int'($urandom_range(0, 17999));
         4: big_v = pick_big_boundary();
         5: big_v = -int'($urandom_range(996, 32768));
         default: big_v = int'($urandom_range(19996, 32767));
      endcase
      case ($urandom_range(0, 5))
         0: small_v = int'($urandom_range(0, 65535));
         1, 2: small_v = int'($urandom_range(0, 108)) - 9;
         3: begin
            case ($urandom_range(0, 7))
               0: small_v = 99;   1: small_v = 100;  2: small_v = -9;  3: small_v = -10;
               4: small_v = 9;    5: small_v = 10;   6: small_v = 0;   default: small_v = -1;
            endcase
         end
         4: small_v = int'($urandom_range(100, 32767));
         default: small_v = -int'($urandom_range(10, 32768));
      endcase
      if ($urandom_range(0, 1) == 0) begin
         level = int'($urandom_range(0, 255));
      end else begin
         level = 20 + 16 * int'($urandom_range(0, 4)) + int'($urandom_range(0, 1));
      end
      add_update(big_v, small_v, $urandom_range(0, 1), $urandom_range(0, 3) != 0, level,
                 $urandom_range(0, 7), $urandom_range(0, 7));
   endtask

   // Drain everything in flight before touching the register
   task automatic wait_idle();
      while (pending_updates.size() != 0 || req_tvalid || expected_frames.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write display_enabled, then read it back
   task automatic set_display_enable(input bit value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DISPLAY_ENABLE_ADDR;
      csr_pwdata  <= {31'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      panel_enabled = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'b0, value})
         report_mismatch($sformatf("display_enabled read %h, wrote %0d", csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Source: present queued words, with bursts of idle cycles between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (src_gap > 0) begin
            src_gap--;
            req_tvalid <= 1'b0;
         end else if (!no_idling && $urandom_range(0, 99) < src_idle_pct) begin
            src_gap = $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else if (pending_updates.size() != 0) begin
            req_tdata  <= pending_updates.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Sink: stall in bursts; this block also re-picks both idle rates, counting with rate_cycle
   always @(posedge clock) begin
      rate_cycle++;
      if (rate_cycle % 64 == 0) begin
         case ($urandom_range(0, 2))
            0: src_idle_pct = 0;
            1: src_idle_pct = 8;
            default: src_idle_pct = 25;
         endcase
         case ($urandom_range(0, 2))
            0: sink_idle_pct = 0;
            1: sink_idle_pct = 8;
            default: sink_idle_pct = 25;
         endcase
      end
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap = 0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_tready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 99) < sink_idle_pct) begin
         sink_gap = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: check result words first, then predict for the word taken this edge
   always @(posedge clock) begin : monitor
      panel_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("frame %h with nothing expected", rsp_tdata));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata !== want.frame)
                  report_mismatch($sformatf("frame %h, expected %h", rsp_tdata, want.frame));
               if (rsp_tuser !== want.changed)
                  report_mismatch($sformatf("changed %b, expected %b for frame %h",
                                            rsp_tuser, want.changed, want.frame));
            end
         end
         if (req_tvalid && req_tready)
            expected_frames.push_back(compose_panel(lcd_update_type'(req_tdata)));

         // watchdog on words moving either way or a register access
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[segment_lcd_frame_composer] ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      set_display_enable(1'b1);

      // directed: field extremes, Hi/Lo edges, rounding, point, minus, bars
      add_update(19995, 99, 1, 1, 255, 7, 7);
      add_update(19996, 100, 0, 0, 0, 0, 0);
      add_update(-995, -9, 1, 1, 85, 1, 1);
      add_update(-996, -10, 0, 1, 84, 2, 2);
      add_update(1995, 0, 1, 1, 69, 4, 4);
      add_update(1996, 9, 0, 1, 68, 3, 5);
      add_update(0, -1, 1, 1, 53, 5, 6);
      add_update(-32768, -32768, 0, 1, 52, 6, 3);
      add_update(32767, 32767, 1, 1, 37, 7, 0);
      add_update(1000, 10, 0, 1, 36, 0, 7);
      add_update(999, 50, 1, 1, 21, 1, 2);
      add_update(99, 1, 0, 1, 20, 2, 4);
      add_update(9, 5, 1, 1, 0, 4, 1);
      add_update(-5, 98, 0, 0, 255, 0, 0);
      add_update(-5, 98, 0, 0, 255, 0, 0);
      add_update(2004, 9, 1, 1, 255, 7, 7);
      add_update(2005, -9, 0, 1, 170, 2, 5);
      add_update(10, 11, 1, 0, 85, 1, 3);
      add_update(-999, 100, 0, 1, 255, 6, 6);
      add_update(19994, -10, 1, 1, 128, 5, 1);
      wait_idle();

      // display off: no frame marked for sending
      set_display_enable(1'b0);
      repeat (200) add_random_update();
      wait_idle();

      set_display_enable(1'b1);
      repeat (400) add_random_update();
      wait_idle();

      set_display_enable(1'b0);
      repeat (75) add_random_update();
      wait_idle();

      // closing stretch at full rate
      set_display_enable(1'b1);
      no_idling = 1'b1;
      repeat (400) add_random_update();
      wait_idle();
      repeat (8) @(posedge clock);

      if (expected_frames.size() != 0)
         report_mismatch($sformatf("%0d frames never arrived", expected_frames.size()));
      if (error_count == 0)
         $display("[segment_lcd_frame_composer] OK");
      else
         $display("[segment_lcd_frame_composer] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/slcd_pkg.sv
src/slcd_csr.sv
src/slcd_big_field.sv
src/slcd_small_field.sv
src/segment_lcd_frame_composer.sv
dv/tb_segment_lcd_frame_composer.sv
